### rtl/bdq_pkg.sv
// ============================================================================
// bdq_pkg
// Shared widths, command codes and status codes of the bounded deque.
// ============================================================================
package bdq_pkg;

  localparam int unsigned BDQ_DEPTH_DEF = 16;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned OUT_W   = 8;

  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [OCC_W-1:0]  occupancy;
    logic [STAT_W-1:0] status;
    logic              found;
  } bdq_res_t;

endpackage

### rtl/bdq_ram.sv
// ============================================================================
// bdq_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/bounded_deque_with_search.sv
// ============================================================================
// bounded_deque_with_search
// Double-ended queue of signed 32-bit values in a ring RAM, with a search.
// ============================================================================
// The input channel carries one command per transfer: in_tuser holds the
// command kind and in_tdata the value. Every command produces exactly one
// result transfer holding the found flag, a status code and the occupancy
// after the command. Pushes and pops are taken one per cycle while in_tready
// is high, and their result is registered on acceptance. A membership query
// reads the ring RAM one held entry per cycle from the front and stops at
// the first match or after the last held value, holding in_tready low for
// the search; a query on an empty store reports not found without reading
// the RAM. The single read port of the RAM sets that pace. Pushing onto a
// full store or popping an empty one leaves the contents unchanged and
// reports it in the status. After reset the deque is empty; the RAM is not
// cleared. A result that the receiver does not take waits in the output
// register, and one further result can wait in a second register, after
// which in_tready is held low until the receiver takes a transfer.
// ============================================================================
module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = BDQ_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // value
  input  logic [KIND_W-1:0]  in_tuser,   // kind
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata   // found, status, occupancy
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic               state_r, state_nxt;
  logic [AW-1:0]      front_r, front_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      issued_r, issued_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;

  logic               out_valid_r;
  bdq_res_t           out_res_r;
  logic               pend_valid_r;
  bdq_res_t           pend_res_r;

  logic               in_xfer;
  logic               out_free;
  logic               full;
  logic               empty;
  logic               hit;
  logic [AW-1:0]      front_inc;
  logic [AW-1:0]      front_dec;
  logic [AW-1:0]      ptr_inc;
  logic [CW:0]        back_sum;
  logic [CW:0]        back_wrap;
  logic [AW-1:0]      back_addr;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;

  logic               res_valid;
  bdq_res_t           res;

  bdq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready = (state_r == S_IDLE) && !pend_valid_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign hit   = (rd_data == key_r);

  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + AW'(1);
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
  assign ptr_inc   = (ptr_r == LAST_IDX) ? '0 : ptr_r + AW'(1);

  assign back_sum  = (CW+1)'(front_r) + (CW+1)'(count_r);
  assign back_wrap = (back_sum >= (CW+1)'(DEPTH)) ? back_sum - (CW+1)'(DEPTH) : back_sum;
  assign back_addr = back_wrap[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    issued_nxt    = issued_r;
    key_nxt       = key_r;
    wr_en         = 1'b0;
    wr_addr       = back_addr;
    rd_en         = 1'b0;
    rd_addr       = ptr_r;
    res_valid     = 1'b0;
    res.found     = 1'b0;
    res.status    = STAT_DONE;
    res.occupancy = OCC_W'(count_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_valid = 1'b1;
          unique case (in_tuser)
            KIND_PUSH_BACK: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = back_addr;
                count_nxt = count_r + CW'(1);
              end
            end
            KIND_POP_BACK: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            KIND_PUSH_FRONT: begin
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + CW'(1);
              end
            end
            KIND_POP_FRONT: begin
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                front_nxt = front_inc;
                count_nxt = count_r - CW'(1);
              end
            end
            KIND_QUERY: begin
              if (!empty) begin
                res_valid  = 1'b0;
                rd_en      = 1'b1;
                rd_addr    = front_r;
                ptr_nxt    = front_inc;
                issued_nxt = CW'(1);
                key_nxt    = in_tdata;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
            end
          endcase
          res.occupancy = OCC_W'(count_nxt);
        end
      end
      S_SCAN: begin
        if (hit || (issued_r == count_r)) begin
          res_valid = 1'b1;
          res.found = hit;
          state_nxt = S_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = ptr_r;
          ptr_nxt    = ptr_inc;
          issued_nxt = issued_r + CW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      front_r      <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      if (out_free) begin
        if (pend_valid_r) begin
          out_valid_r  <= 1'b1;
          pend_valid_r <= res_valid;
        end else begin
          out_valid_r <= res_valid;
        end
      end else if (res_valid) begin
        pend_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    issued_r <= issued_nxt;
    key_r    <= key_nxt;
    if (out_free) begin
      if (pend_valid_r) begin
        out_res_r <= pend_res_r;
        if (res_valid) begin
          pend_res_r <= res;
        end
      end else if (res_valid) begin
        out_res_r <= res;
      end
    end else if (res_valid) begin
      pend_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Occupancy exceeds the store depth.");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !wr_en)
    else $error("RAM written during a search.");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (issued_r != '0) && (issued_r <= count_r))
    else $error("Search has read beyond the held entries.");

  a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && pend_valid_r) |-> out_free)
    else $error("Result produced with both result registers occupied.");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.found) |-> (out_res_r.status == STAT_DONE))
    else $error("Found flag set with a status other than done.");

endmodule
